/* hdl/tbpmc_pkg.sv */
// Shared types and codes for the two-button press mode controller.
// Holds the request and result payload structs, the threshold bundle and the
// event, mode and press-class codes. No dependencies.
`default_nettype none

package tbpmc_pkg;

    localparam int unsigned TIME_W   = 15;
    localparam int unsigned TARGET_W = 14;

    // Event kinds carried in a request
    localparam logic [1:0] KIND_ON_PRESS  = 2'd0;
    localparam logic [1:0] KIND_SET_PRESS = 2'd1;
    localparam logic [1:0] KIND_POLL      = 2'd2;
    localparam logic [1:0] KIND_CUTOFF    = 2'd3;

    // Operating modes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_ON  = 2'd1;
    localparam logic [1:0] MODE_SET = 2'd2;
    localparam logic [1:0] MODE_LVC = 2'd3;

    // Press classes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_SHORT = 2'd1;
    localparam logic [1:0] CLS_LONG  = 2'd2;
    localparam logic [1:0] CLS_IDLE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SHORT_THRESHOLD = 1'b0;
    localparam logic CFG_LONG_THRESHOLD  = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] timer_now;
        logic              on_released;
        logic              set_released;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          op_mode;
        logic [3:0]          display_mode;
        logic [1:0]          selected_digit;
        logic [TARGET_W-1:0] target_value;
        logic [1:0]          on_class;
        logic [1:0]          set_class;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] short_threshold;
        logic [TIME_W-1:0] long_threshold;
    } thresh_t;

endpackage

`default_nettype wire

/* hdl/tbpmc_classify.sv */
// Press classifier: wrapped hold time against the short and long thresholds.
// Depends on tbpmc_pkg.
`default_nettype none

module tbpmc_classify
(
    input  wire logic [tbpmc_pkg::TIME_W-1:0] now,
    input  wire logic [tbpmc_pkg::TIME_W-1:0] down_time,
    input  wire tbpmc_pkg::thresh_t           thresh,
    output logic [1:0]                        press_class
);

    logic [tbpmc_pkg::TIME_W-1:0] held;

    // Modular subtract gives the wrapped hold time
    assign held = now - down_time;

    always_comb
    begin
        if (held > thresh.long_threshold)
            press_class = tbpmc_pkg::CLS_LONG;
        else if (held > thresh.short_threshold)
            press_class = tbpmc_pkg::CLS_SHORT;
        else
            press_class = tbpmc_pkg::CLS_NONE;
    end

endmodule

`default_nettype wire

/* hdl/tbpmc_state.sv */
// Controller state and its single-pass update for one request.
// Depends on tbpmc_pkg and tbpmc_classify.
`default_nettype none

module tbpmc_state
#(
    parameter int DISPLAY_MODES   = 6,
    parameter int AMP_HOURS_INDEX = 3,
    parameter int AMPS_INDEX      = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire tbpmc_pkg::in_item_t  item,
    input  wire tbpmc_pkg::thresh_t   thresh,
    output tbpmc_pkg::out_item_t      result
);

    logic                         on_pending_reg,  on_pending_next;
    logic [tbpmc_pkg::TIME_W-1:0] on_down_reg,     on_down_next;
    logic                         set_pending_reg, set_pending_next;
    logic [tbpmc_pkg::TIME_W-1:0] set_down_reg,    set_down_next;
    logic [1:0]                   mode_reg,        mode_next;
    logic [3:0]                   display_reg,     display_next;
    logic [1:0]                   digit_sel_reg,   digit_sel_next;
    logic [3:0]                   digits_reg [4];
    logic [3:0]                   digits_next [4];

    logic [1:0] on_cls_w;
    logic [1:0] set_cls_w;
    logic [1:0] on_cls;
    logic [1:0] set_cls;
    logic       do_on;
    logic       do_set;

    tbpmc_classify u_on_class
    (
        .now         (item.timer_now),
        .down_time   (on_down_reg),
        .thresh      (thresh),
        .press_class (on_cls_w)
    );

    tbpmc_classify u_set_class
    (
        .now         (item.timer_now),
        .down_time   (set_down_reg),
        .thresh      (thresh),
        .press_class (set_cls_w)
    );

    // Next display index; wrap at the mode count, or at amp-hours in set mode
    function automatic logic [3:0] advance_display(input logic [3:0] disp,
                                                   input logic [1:0] mode);
        logic [4:0] d;
        begin
            d = {1'b0, disp} + 5'd1;
            if ((d >= 5'(DISPLAY_MODES)) ||
                ((mode == tbpmc_pkg::MODE_SET) && (d == 5'(AMP_HOURS_INDEX))))
                d = 5'd0;
            return d[3:0];
        end
    endfunction

    // Decimal digit increment, mod 10
    function automatic logic [3:0] digit_inc(input logic [3:0] dig);
        logic [4:0] s;
        begin
            s = {1'b0, dig} + 5'd1;
            if (s >= 5'd10)
                s = s - 5'd10;
            return s[3:0];
        end
    endfunction

    assign do_on  = on_pending_reg && item.on_released;
    assign do_set = set_pending_reg && item.set_released;

    always_comb
    begin
        on_pending_next  = on_pending_reg;
        on_down_next     = on_down_reg;
        set_pending_next = set_pending_reg;
        set_down_next    = set_down_reg;
        mode_next        = mode_reg;
        display_next     = display_reg;
        digit_sel_next   = digit_sel_reg;
        for (int i = 0; i < 4; i++)
            digits_next[i] = digits_reg[i];
        on_cls  = tbpmc_pkg::CLS_IDLE;
        set_cls = tbpmc_pkg::CLS_IDLE;

        if (step)
        begin
            case (item.kind)
                tbpmc_pkg::KIND_ON_PRESS:
                begin
                    if (!on_pending_reg)
                    begin
                        on_pending_next = 1'b1;
                        on_down_next    = item.timer_now;
                    end
                end
                tbpmc_pkg::KIND_SET_PRESS:
                begin
                    if (!set_pending_reg)
                    begin
                        set_pending_next = 1'b1;
                        set_down_next    = item.timer_now;
                    end
                end
                tbpmc_pkg::KIND_CUTOFF:
                begin
                    mode_next = tbpmc_pkg::MODE_LVC;
                end
                default:
                begin
                    // On button first; the set button sees the mode it leaves
                    if (do_on)
                    begin
                        on_cls          = on_cls_w;
                        on_pending_next = 1'b0;
                        case (mode_reg)
                            tbpmc_pkg::MODE_OFF: mode_next = tbpmc_pkg::MODE_ON;
                            tbpmc_pkg::MODE_ON:  mode_next = tbpmc_pkg::MODE_OFF;
                            tbpmc_pkg::MODE_SET:
                            begin
                                if (on_cls_w == tbpmc_pkg::CLS_LONG)
                                    digit_sel_next = (digit_sel_reg >= 2'd2) ?
                                                     digit_sel_reg - 2'd2 :
                                                     digit_sel_reg + 2'd1;
                                else
                                    for (int i = 0; i < 4; i++)
                                        if (digit_sel_reg == 2'(i))
                                            digits_next[i] = digit_inc(digits_reg[i]);
                            end
                            default: ;
                        endcase
                    end

                    if (do_set)
                    begin
                        set_cls          = set_cls_w;
                        set_pending_next = 1'b0;
                        case (mode_next)
                            tbpmc_pkg::MODE_ON:
                                display_next = advance_display(display_reg, mode_next);
                            tbpmc_pkg::MODE_OFF:
                            begin
                                if (set_cls_w == tbpmc_pkg::CLS_LONG)
                                begin
                                    display_next = 4'(AMPS_INDEX);
                                    mode_next    = tbpmc_pkg::MODE_SET;
                                end
                                else
                                    display_next = advance_display(display_reg, mode_next);
                            end
                            tbpmc_pkg::MODE_SET:
                            begin
                                if (set_cls_w == tbpmc_pkg::CLS_LONG)
                                    mode_next = tbpmc_pkg::MODE_OFF;
                                else
                                    display_next = advance_display(display_reg, mode_next);
                            end
                            default:
                            begin
                                if (set_cls_w == tbpmc_pkg::CLS_LONG)
                                    mode_next = tbpmc_pkg::MODE_OFF;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_pending_reg  <= 1'b0;
            on_down_reg     <= '0;
            set_pending_reg <= 1'b0;
            set_down_reg    <= '0;
            mode_reg        <= tbpmc_pkg::MODE_OFF;
            display_reg     <= 4'd0;
            digit_sel_reg   <= 2'd0;
            for (int i = 0; i < 4; i++)
                digits_reg[i] <= 4'd0;
        end
        else
        begin
            on_pending_reg  <= on_pending_next;
            on_down_reg     <= on_down_next;
            set_pending_reg <= set_pending_next;
            set_down_reg    <= set_down_next;
            mode_reg        <= mode_next;
            display_reg     <= display_next;
            digit_sel_reg   <= digit_sel_next;
            for (int i = 0; i < 4; i++)
                digits_reg[i] <= digits_next[i];
        end
    end

    // Result reflects the state after this request
    always_comb
    begin
        result.op_mode        = mode_next;
        result.display_mode   = display_next;
        result.selected_digit = digit_sel_next;
        result.target_value   = 14'(digits_next[3]) * 14'd1000 +
                                14'(digits_next[2]) * 14'd100 +
                                14'(digits_next[1]) * 14'd10 +
                                14'(digits_next[0]);
        result.on_class       = on_cls;
        result.set_class      = set_cls;
    end

    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_sel_reg != 2'd3)
        else $error("selected digit left the range of three");

    a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
        digits_reg[3] == 4'd0)
        else $error("top target digit changed");

    a_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.kind == tbpmc_pkg::KIND_CUTOFF)) |=> (mode_reg == tbpmc_pkg::MODE_LVC))
        else $error("cutoff event did not enter cutoff mode");

    a_press_no_class: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.kind != tbpmc_pkg::KIND_POLL)) |=>
        ($past(result.on_class) == tbpmc_pkg::CLS_IDLE &&
         $past(result.set_class) == tbpmc_pkg::CLS_IDLE &&
         $past(digit_sel_next) == digit_sel_reg))
        else $error("non-poll request classed a press");

endmodule

`default_nettype wire

/* hdl/two_button_press_mode_controller_top.sv */
// Top level of the two-button press mode controller: request and result
// channels, threshold registers, input and result registers.
// Depends on tbpmc_pkg and tbpmc_state.
//
// Usage:
//   Requests arrive on in_valid/in_data and are taken at a rising edge with
//   in_valid high and in_stall low. Each request is an on press, a set press,
//   a pin poll or a low-voltage cutoff event, with the tick counter and the
//   two pin levels. Every request yields exactly one result on
//   out_valid/out_data: the mode, display index, selected digit, target value
//   and the class of any press released on this poll.
//   A request lands in the input register, is applied to the controller
//   state in one pass of compare and update logic, and the result is
//   captured in the result register. Throughput is one request per cycle
//   while out_stall is low, set by that single-pass update of the state.
//   When the receiver holds out_stall, the result register holds and the
//   input register can still take one request; in_stall rises only when both
//   registers are full and the result is stalled.
//   Thresholds are written through cfg_write/cfg_index/cfg_data while idle.
//   Reset clears pending presses, mode (off), display, digit select and the
//   target digits, and loads thresholds of 50 and 1000 ticks.
`default_nettype none

module two_button_press_mode_controller_top
#(
    parameter int DISPLAY_MODES   = 6,
    parameter int AMP_HOURS_INDEX = 3,
    parameter int AMPS_INDEX      = 0
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire tbpmc_pkg::in_item_t           in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output tbpmc_pkg::out_item_t               out_data,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [tbpmc_pkg::TIME_W-1:0]  cfg_data
);

    tbpmc_pkg::thresh_t   thresh_reg;
    logic                 req_valid_reg;
    tbpmc_pkg::in_item_t  req_reg;
    logic                 res_valid_reg;
    tbpmc_pkg::out_item_t res_reg;
    tbpmc_pkg::out_item_t result;
    logic                 advance;

    // Result register frees up when empty or being taken this cycle
    assign advance   = !res_valid_reg || !out_stall;
    assign in_stall  = req_valid_reg && !advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_threshold <= 15'd50;
            thresh_reg.long_threshold  <= 15'd1000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tbpmc_pkg::CFG_SHORT_THRESHOLD: thresh_reg.short_threshold <= cfg_data;
                tbpmc_pkg::CFG_LONG_THRESHOLD:  thresh_reg.long_threshold  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: hold while the request cannot move on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (!in_stall)
            req_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    tbpmc_state
    #(
        .DISPLAY_MODES   (DISPLAY_MODES),
        .AMP_HOURS_INDEX (AMP_HOURS_INDEX),
        .AMPS_INDEX      (AMPS_INDEX)
    )
    u_state
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (req_valid_reg && advance),
        .item   (req_reg),
        .thresh (thresh_reg),
        .result (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= req_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg && advance)
            res_reg <= result;
    end

    a_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && advance) |=> res_valid_reg)
        else $error("applied request produced no result");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (res_valid_reg && out_stall))
        else $error("input stalled with room in the result register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_stall && req_valid_reg) |=> req_valid_reg)
        else $error("pending request dropped while result stalled");

endmodule

`default_nettype wire
